// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top level of the card number check core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define CNLC_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define CNLC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CNLC_ASSERT_SAME(name, clk, rst, ante, cons)
`define CNLC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/cnlc_pkg.sv -----
// Package with the types, constants and helper functions of the card number check core.
`default_nettype none
package cnlc_pkg;

   // Field widths fixed by the interface.
   localparam int CARD_W  = 54;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;
   localparam int PAIR_W  = 7;

   // Decimal digit storage.
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 17;
   localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int BITCNT_W   = $clog2(CARD_W);

   // Card kind codes.
   localparam logic [KIND_W-1:0] KIND_INVALID    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_AMEX       = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MASTERCARD = 2'd2;
   localparam logic [KIND_W-1:0] KIND_VISA       = 2'd3;

   // Digit counts and leading digits used by the classes.
   localparam logic [COUNT_W-1:0] LEN_AMEX  = 5'd15;
   localparam logic [COUNT_W-1:0] LEN_LONG  = 5'd16;
   localparam logic [COUNT_W-1:0] LEN_SHORT = 5'd13;
   localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE  = 4'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_FOUR = 4'd4;
   localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_SEVEN = 4'd7;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

   // Summary of one scanned number, handed from the digit scanner to the top level.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [DIGIT_W-1:0] lead_hi;
      logic [DIGIT_W-1:0] lead_lo;
      logic               sum_zero;
   } scan_result_type;

   // Digit sum of twice a decimal digit.
   function automatic logic [DIGIT_W-1:0] doubled_digit_sum(input logic [DIGIT_W-1:0] d);
      logic [DIGIT_W-1:0] r;
      begin
         unique case (d)
            4'd0: r = 4'd0;
            4'd1: r = 4'd2;
            4'd2: r = 4'd4;
            4'd3: r = 4'd6;
            4'd4: r = 4'd8;
            4'd5: r = 4'd1;
            4'd6: r = 4'd3;
            4'd7: r = 4'd5;
            4'd8: r = 4'd7;
            4'd9: r = 4'd9;
            default: r = 4'd0;
         endcase
         return r;
      end
   endfunction

   // Card class from the digit count and the two leading digits.
   function automatic logic [KIND_W-1:0] classify(
      input logic [COUNT_W-1:0] count,
      input logic [DIGIT_W-1:0] hi,
      input logic [DIGIT_W-1:0] lo
   );
      logic [KIND_W-1:0] k;
      begin
         priority if (count == LEN_AMEX && hi == DIGIT_THREE &&
                      (lo == DIGIT_FOUR || lo == DIGIT_SEVEN)) begin
            k = KIND_AMEX;
         end else if (count == LEN_LONG && hi == DIGIT_FIVE &&
                      lo >= DIGIT_ONE && lo <= DIGIT_FIVE) begin
            k = KIND_MASTERCARD;
         end else if ((count == LEN_SHORT || count == LEN_LONG) && hi == DIGIT_FOUR) begin
            k = KIND_VISA;
         end else begin
            k = KIND_INVALID;
         end
         return k;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cnlc_bin2bcd.sv -----
// Bit-serial binary to decimal converter (shift and add three), one input bit per cycle while shift_en is high.
`default_nettype none
module cnlc_bin2bcd (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         load,
   input  wire logic                         shift_en,
   input  wire logic [cnlc_pkg::CARD_W-1:0]  value,
   output logic      [cnlc_pkg::BCD_W-1:0]   bcd,
   output logic                              last
);

   logic [cnlc_pkg::CARD_W-1:0]   bin_ff, bin_in;
   logic [cnlc_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [cnlc_pkg::BCD_W-1:0]    adjusted;
   logic [cnlc_pkg::BITCNT_W-1:0] cnt_ff, cnt_in;

   // Each decimal digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < cnlc_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] >= cnlc_pkg::DIGIT_FIVE) begin
            adjusted[i*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
               bcd_ff[i*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] + cnlc_pkg::DIGIT_THREE;
         end else begin
            adjusted[i*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W] =
               bcd_ff[i*cnlc_pkg::DIGIT_W +: cnlc_pkg::DIGIT_W];
         end
      end
   end

   // Load the number, or move its top bit into the decimal register.
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (load) begin
         bin_in = value;
         bcd_in = '0;
         cnt_in = '0;
      end else if (shift_en) begin
         bin_in = {bin_ff[cnlc_pkg::CARD_W-2:0], 1'b0};
         bcd_in = {adjusted[cnlc_pkg::BCD_W-2:0], bin_ff[cnlc_pkg::CARD_W-1]};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign bcd  = bcd_ff;
   assign last = (cnt_ff == cnlc_pkg::BITCNT_W'(cnlc_pkg::CARD_W - 1));

endmodule
`default_nettype wire

// ----- hw/rtl/cnlc_digit_scan.sv -----
// Digit scanner: walks the decimal digits from the low end, one per cycle while step_en is high.
`default_nettype none
module cnlc_digit_scan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        load,
   input  wire logic                        step_en,
   input  wire logic [cnlc_pkg::BCD_W-1:0]  bcd,
   output cnlc_pkg::scan_result_type        result,
   output logic                             last
);

   logic [cnlc_pkg::BCD_W-1:0]   digits_ff, digits_in;
   logic [cnlc_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic [cnlc_pkg::DIGIT_W-1:0] sum_ff, sum_in;
   logic [cnlc_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [cnlc_pkg::DIGIT_W-1:0] hi_ff, hi_in;
   logic [cnlc_pkg::DIGIT_W-1:0] lo_ff, lo_in;
   logic [cnlc_pkg::DIGIT_W-1:0] prev_ff, prev_in;
   logic [cnlc_pkg::DIGIT_W-1:0] digit;
   logic [cnlc_pkg::DIGIT_W-1:0] contrib;
   logic [cnlc_pkg::DIGIT_W:0]   sum_wide;

   assign digit = digits_ff[cnlc_pkg::DIGIT_W-1:0];

   // Each digit at an odd index (zero at the right) is doubled before it is added.
   always_comb begin
      if (idx_ff[0]) begin
         contrib = cnlc_pkg::doubled_digit_sum(digit);
      end else begin
         contrib = digit;
      end
      sum_wide = {1'b0, sum_ff} + {1'b0, contrib};
   end

   // Keep the Luhn sum modulo ten; track the highest nonzero digit and the one below it.
   always_comb begin
      digits_in = digits_ff;
      idx_in    = idx_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      prev_in   = prev_ff;
      if (load) begin
         digits_in = bcd;
         idx_in    = '0;
         sum_in    = '0;
         count_in  = '0;
         hi_in     = '0;
         lo_in     = '0;
         prev_in   = '0;
      end else if (step_en) begin
         digits_in = {{cnlc_pkg::DIGIT_W{1'b0}}, digits_ff[cnlc_pkg::BCD_W-1:cnlc_pkg::DIGIT_W]};
         idx_in    = idx_ff + 1'b1;
         prev_in   = digit;
         if (sum_wide >= {1'b0, cnlc_pkg::DIGIT_TEN}) begin
            sum_in = cnlc_pkg::DIGIT_W'(sum_wide - {1'b0, cnlc_pkg::DIGIT_TEN});
         end else begin
            sum_in = sum_wide[cnlc_pkg::DIGIT_W-1:0];
         end
         if (digit != cnlc_pkg::DIGIT_ZERO) begin
            count_in = cnlc_pkg::COUNT_W'(idx_ff) + 1'b1;
            if (idx_ff == '0) begin
               // A single-digit number reports the digit itself.
               hi_in = cnlc_pkg::DIGIT_ZERO;
               lo_in = digit;
            end else begin
               hi_in = digit;
               lo_in = prev_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      sum_ff    <= sum_in;
      count_ff  <= count_in;
      hi_ff     <= hi_in;
      lo_ff     <= lo_in;
      prev_ff   <= prev_in;
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign result.count    = count_ff;
   assign result.lead_hi  = hi_ff;
   assign result.lead_lo  = lo_ff;
   assign result.sum_zero = (sum_ff == cnlc_pkg::DIGIT_ZERO);
   assign last = (idx_ff == cnlc_pkg::IDX_W'(cnlc_pkg::NUM_DIGITS - 1));

endmodule
`default_nettype wire

// ----- hw/rtl/card_number_luhn_classifier_core.sv -----
// Luhn check and card classification: one request is converted to decimal bit by bit,
// its 17 decimal digits are scanned one per cycle, and one result is delivered.
// A request passes through 54 one-bit conversion steps, a scanner load and 17
// digit-scan steps before its result is registered; a new request is taken only once
// the sequencer is idle again, and the output register lets the next request in while
// a result still waits. Synchronous active-high reset empties the control path.
`default_nettype none
`include "assert_macros.svh"
module card_number_luhn_classifier_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [cnlc_pkg::CARD_W-1:0]   req_card_number,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [cnlc_pkg::KIND_W-1:0]   rsp_card_kind,
   output logic                               rsp_luhn_ok,
   output logic      [cnlc_pkg::COUNT_W-1:0]  rsp_digit_count,
   output logic      [cnlc_pkg::PAIR_W-1:0]   rsp_leading_pair
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CONV = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       req_take;
   logic       conv_shift;
   logic       conv_last;
   logic       scan_load;
   logic       scan_step;
   logic       scan_last;
   logic       rsp_load;
   logic [cnlc_pkg::BCD_W-1:0] bcd;
   cnlc_pkg::scan_result_type  scan_res;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cnlc_pkg::KIND_W-1:0]  kind_ff;
   logic                         ok_ff;
   logic [cnlc_pkg::COUNT_W-1:0] count_ff;
   logic [cnlc_pkg::PAIR_W-1:0]  pair_ff;
   logic [cnlc_pkg::PAIR_W-1:0]  pair;
   logic [cnlc_pkg::KIND_W-1:0]  kind;

   // A new request enters only when the sequencer is idle.
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   cnlc_bin2bcd u_bin2bcd (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .shift_en (conv_shift),
      .value    (req_card_number),
      .bcd      (bcd),
      .last     (conv_last)
   );

   cnlc_digit_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .load    (scan_load),
      .step_en (scan_step),
      .bcd     (bcd),
      .result  (scan_res),
      .last    (scan_last)
   );

   // Sequencer: convert, load the scanner, scan, then hand over to the output register.
   always_comb begin
      state_in   = state_ff;
      conv_shift = 1'b0;
      scan_load  = 1'b0;
      scan_step  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            conv_shift = 1'b1;
            if (conv_last) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            scan_load = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            scan_step = 1'b1;
            if (scan_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Leading pair as a binary value, and the class when the check passes.
   always_comb begin
      pair = (cnlc_pkg::PAIR_W'(scan_res.lead_hi) << 3) +
             (cnlc_pkg::PAIR_W'(scan_res.lead_hi) << 1) +
             cnlc_pkg::PAIR_W'(scan_res.lead_lo);
      if (scan_res.sum_zero) begin
         kind = cnlc_pkg::classify(scan_res.count, scan_res.lead_hi, scan_res.lead_lo);
      end else begin
         kind = cnlc_pkg::KIND_INVALID;
      end
   end

   // Output register holds a result until the receiver takes it.
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         kind_ff  <= kind;
         ok_ff    <= scan_res.sum_zero;
         count_ff <= scan_res.count;
         pair_ff  <= pair;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_card_kind    = kind_ff;
   assign rsp_luhn_ok      = ok_ff;
   assign rsp_digit_count  = count_ff;
   assign rsp_leading_pair = pair_ff;

   // A classified card always passed the check and has a plausible length.
   `CNLC_ASSERT_SAME(a_kind_needs_ok, clock, reset, rsp_valid_ff && kind_ff != cnlc_pkg::KIND_INVALID, ok_ff)
   `CNLC_ASSERT_SAME(a_kind_length, clock, reset, rsp_valid_ff && kind_ff != cnlc_pkg::KIND_INVALID, count_ff >= cnlc_pkg::LEN_SHORT && count_ff <= cnlc_pkg::LEN_LONG)
   // An accepted request always starts the conversion.
   `CNLC_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == S_CONV)

endmodule
`default_nettype wire
